/* sv/cel_pkg.sv */
// shared types, codes and sizes of the csr edge lookup block
package cel_pkg;

   localparam int MAX_NODES = 4096;
   localparam int MAX_EDGES = 16384;

   localparam int NODE_ID_W = 13;
   localparam int EDGE_IDX_W = 14;
   localparam int OFFSET_W = 15;
   localparam int PAT_W = 8;
   localparam int WORD_W = 16;
   localparam int DEPTH_W = 8;
   localparam int CHILD_W = 12;
   localparam int STATUS_W = 3;

   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;

   // command codes of an input item
   localparam logic [1:0] CMD_NODE_WR = 2'd0;
   localparam logic [1:0] CMD_EDGE_WR = 2'd1;
   localparam logic [1:0] CMD_LOOKUP = 2'd2;

   // result status codes
   localparam logic [STATUS_W-1:0] STAT_FOUND = 3'd0;
   localparam logic [STATUS_W-1:0] STAT_SOLVED = 3'd1;
   localparam logic [STATUS_W-1:0] STAT_RANGE = 3'd2;
   localparam logic [STATUS_W-1:0] STAT_NOEDGE = 3'd3;
   localparam logic [STATUS_W-1:0] STAT_WRITTEN = 3'd4;

   // register indexes, selected by paddr[2]
   localparam logic REG_NODE_LIMIT = 1'b0;
   localparam logic REG_SOLVED_PATTERN = 1'b1;

   localparam logic [NODE_ID_W-1:0] NODE_LIMIT_RESET = 13'd0;
   localparam logic [PAT_W-1:0] SOLVED_PATTERN_RESET = 8'd242;

   typedef struct packed {
      logic [1:0]            command;
      logic [NODE_ID_W-1:0]  node_id;
      logic [EDGE_IDX_W-1:0] edge_index;
      logic [PAT_W-1:0]      pattern;
      logic [WORD_W-1:0]     word_index;
      logic [DEPTH_W-1:0]    node_depth;
      logic [OFFSET_W-1:0]   edge_offset;
      logic [CHILD_W-1:0]    child;
   } req_type;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [CHILD_W-1:0]  child_node;
      logic [WORD_W-1:0]   word_index_out;
      logic [DEPTH_W-1:0]  depth_out;
   } rsp_type;

   typedef struct packed {
      logic [NODE_ID_W-1:0] node_limit;
      logic [PAT_W-1:0]     solved_pattern;
   } cfg_type;

   typedef enum logic [2:0] {
      OP_NODE_WR,
      OP_EDGE_WR,
      OP_WR_SKIP,
      OP_RANGE,
      OP_SOLVED,
      OP_SEARCH
   } op_type;

   typedef struct packed {
      op_type                op;
      logic [NODE_ID_W-1:0]  node_id;
      logic [EDGE_IDX_W-1:0] edge_index;
      logic [PAT_W-1:0]      pattern;
      logic [WORD_W-1:0]     word_index;
      logic [DEPTH_W-1:0]    node_depth;
      logic [OFFSET_W-1:0]   edge_offset;
      logic [CHILD_W-1:0]    child;
   } cmd_type;

   typedef struct packed {
      logic [WORD_W-1:0]   word_index;
      logic [DEPTH_W-1:0]  node_depth;
      logic [OFFSET_W-1:0] edge_offset;
   } node_rec_type;

   typedef struct packed {
      logic [PAT_W-1:0]   pattern;
      logic [CHILD_W-1:0] child;
   } edge_rec_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_NODE,
      ST_PROBE,
      ST_CMP,
      ST_LAST_RD,
      ST_LAST
   } state_type;

endpackage

/* sv/cel_front.sv */
// front end: accepts items and classifies them into queued commands
module cel_front (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  cel_pkg::req_type  req_item,
   input  cel_pkg::cfg_type  cfg,
   output logic              push_valid,
   input  logic              push_ready,
   output cel_pkg::cmd_type  push_item
);
   import cel_pkg::*;

   logic range_bad;
   logic node_wr_ok;
   logic edge_wr_ok;
   logic cmd_known;

   assign range_bad = (req_item.node_id >= cfg.node_limit)
                   || (req_item.node_id >= NODE_ID_W'(MAX_NODES));
   // the sentinel slot is writable
   assign node_wr_ok = req_item.node_id <= NODE_ID_W'(MAX_NODES);
   assign edge_wr_ok = {1'b0, req_item.edge_index} < (EDGE_IDX_W + 1)'(MAX_EDGES);
   assign cmd_known = (req_item.command == CMD_NODE_WR) || (req_item.command == CMD_EDGE_WR)
                   || (req_item.command == CMD_LOOKUP);

   // unused command code is taken and dropped
   assign req_ready = push_ready;
   assign push_valid = req_valid && cmd_known;

   always_comb begin
      push_item.node_id = req_item.node_id;
      push_item.edge_index = req_item.edge_index;
      push_item.pattern = req_item.pattern;
      push_item.word_index = req_item.word_index;
      push_item.node_depth = req_item.node_depth;
      push_item.edge_offset = req_item.edge_offset;
      push_item.child = req_item.child;
      unique case (req_item.command)
         CMD_NODE_WR: begin
            push_item.op = node_wr_ok ? OP_NODE_WR : OP_WR_SKIP;
         end
         CMD_EDGE_WR: begin
            push_item.op = edge_wr_ok ? OP_EDGE_WR : OP_WR_SKIP;
         end
         CMD_LOOKUP: begin
            priority if (range_bad) begin
               push_item.op = OP_RANGE;
            end else if (req_item.pattern == cfg.solved_pattern) begin
               push_item.op = OP_SOLVED;
            end else begin
               push_item.op = OP_SEARCH;
            end
         end
         default: begin
            push_item.op = OP_WR_SKIP;
         end
      endcase
   end

   property p_drop_only_unknown;
      @(posedge clock) disable iff (reset)
         (req_valid && !push_valid) |-> !cmd_known;
   endproperty
   a_drop_only_unknown: assert property (p_drop_only_unknown)
      else $error("known command dropped by front end");

endmodule

/* sv/cel_queue.sv */
// two-entry command queue between front and back
module cel_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push_valid,
   output logic              push_ready,
   input  cel_pkg::cmd_type  push_item,
   output logic              pop_valid,
   input  logic              pop_ready,
   output cel_pkg::cmd_type  pop_item
);
   import cel_pkg::*;

   cmd_type    q_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] cnt_ff, cnt_in;
   logic       do_push, do_pop;

   assign push_ready = cnt_ff != 2'd2;
   assign pop_valid = cnt_ff != 2'd0;
   assign pop_item = q_ff[rd_ptr_ff];
   assign do_push = push_valid && push_ready;
   assign do_pop = pop_valid && pop_ready;

   always_comb begin
      wr_ptr_in = do_push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = do_pop ? ~rd_ptr_ff : rd_ptr_ff;
      cnt_in = cnt_ff + {1'b0, do_push} - {1'b0, do_pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         cnt_ff <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         q_ff[wr_ptr_ff] <= push_item;
      end
   end

   property p_ptrs_match_count;
      @(posedge clock) disable iff (reset)
         (cnt_ff == 2'd0 || cnt_ff == 2'd2) |-> (wr_ptr_ff == rd_ptr_ff);
   endproperty
   a_ptrs_match_count: assert property (p_ptrs_match_count)
      else $error("queue pointers disagree with fill count");

endmodule

/* sv/cel_back.sv */
// back end: record stores, binary-search sequencer and result register
module cel_back (
   input  logic              clock,
   input  logic              reset,
   input  logic              pop_valid,
   output logic              pop_ready,
   input  cel_pkg::cmd_type  pop_item,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output cel_pkg::rsp_type  rsp_item
);
   import cel_pkg::*;

   function automatic logic [OFFSET_W-1:0] clamp_off(input logic [OFFSET_W-1:0] off);
      return (off > OFFSET_W'(MAX_EDGES)) ? OFFSET_W'(MAX_EDGES) : off;
   endfunction

   node_rec_type node_mem [0:MAX_NODES];
   edge_rec_type edge_mem [0:MAX_EDGES-1];

   node_rec_type node_a_q, node_b_q;
   edge_rec_type edge_q;

   logic                  node_we;
   logic [NODE_ID_W-1:0]  node_rd_a, node_rd_b;
   logic                  edge_we;
   logic [EDGE_IDX_W-1:0] edge_rd_addr;

   state_type           st_ff, st_in;
   logic [OFFSET_W-1:0] lo_ff, lo_in;
   logic [OFFSET_W-1:0] len_ff, len_in;
   logic [OFFSET_W-1:0] end_ff, end_in;
   logic [PAT_W-1:0]    pat_ff, pat_in;
   logic                solv_ff, solv_in;
   logic [WORD_W-1:0]   word_ff, word_in;
   logic [DEPTH_W-1:0]  depth_ff, depth_in;
   logic                rsp_valid_ff, rsp_valid_in;
   rsp_type             rsp_ff, rsp_in;

   logic [OFFSET_W-1:0] half, mid, beg_off, end_off, len_next;
   logic                rsp_free;

   assign rsp_free = !rsp_valid_ff || rsp_ready;
   assign half = len_ff >> 1;
   assign mid = lo_ff + half;
   assign beg_off = clamp_off(node_a_q.edge_offset);
   assign end_off = clamp_off(node_b_q.edge_offset);
   assign len_next = len_ff - half - OFFSET_W'(1);

   assign rsp_valid = rsp_valid_ff;
   assign rsp_item = rsp_ff;

   always_comb begin
      st_in = st_ff;
      lo_in = lo_ff;
      len_in = len_ff;
      end_in = end_ff;
      pat_in = pat_ff;
      solv_in = solv_ff;
      word_in = word_ff;
      depth_in = depth_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_in = rsp_ff;
      pop_ready = 1'b0;
      node_we = 1'b0;
      edge_we = 1'b0;
      node_rd_a = pop_item.node_id;
      node_rd_b = pop_item.node_id + NODE_ID_W'(1);
      edge_rd_addr = mid[EDGE_IDX_W-1:0];
      unique case (st_ff)
         ST_IDLE: begin
            pop_ready = rsp_free;
            if (pop_valid && rsp_free) begin
               pat_in = pop_item.pattern;
               solv_in = pop_item.op == OP_SOLVED;
               rsp_in = '0;
               unique case (pop_item.op)
                  OP_NODE_WR: begin
                     node_we = 1'b1;
                     rsp_in.status = STAT_WRITTEN;
                     rsp_valid_in = 1'b1;
                  end
                  OP_EDGE_WR: begin
                     edge_we = 1'b1;
                     rsp_in.status = STAT_WRITTEN;
                     rsp_valid_in = 1'b1;
                  end
                  OP_WR_SKIP: begin
                     rsp_in.status = STAT_WRITTEN;
                     rsp_valid_in = 1'b1;
                  end
                  OP_RANGE: begin
                     rsp_in.status = STAT_RANGE;
                     rsp_valid_in = 1'b1;
                  end
                  OP_SOLVED, OP_SEARCH: begin
                     st_in = ST_NODE;
                  end
                  default: begin
                     rsp_in.status = STAT_WRITTEN;
                     rsp_valid_in = 1'b1;
                  end
               endcase
            end
         end
         ST_NODE: begin
            word_in = node_a_q.word_index;
            depth_in = node_a_q.node_depth;
            rsp_in.status = STAT_NOEDGE;
            rsp_in.child_node = '0;
            rsp_in.word_index_out = node_a_q.word_index;
            rsp_in.depth_out = node_a_q.node_depth;
            priority if (solv_ff) begin
               rsp_in.status = STAT_SOLVED;
               rsp_valid_in = 1'b1;
               st_in = ST_IDLE;
            end else if (beg_off < end_off) begin
               lo_in = beg_off;
               len_in = end_off - beg_off;
               end_in = end_off;
               st_in = ST_PROBE;
            end else begin
               // reversed or empty slice
               rsp_valid_in = 1'b1;
               st_in = ST_IDLE;
            end
         end
         ST_PROBE: begin
            edge_rd_addr = mid[EDGE_IDX_W-1:0];
            st_in = ST_CMP;
         end
         ST_CMP: begin
            if (edge_q.pattern < pat_ff) begin
               lo_in = mid + OFFSET_W'(1);
               len_in = len_next;
            end else begin
               len_in = half;
            end
            st_in = (len_in == '0) ? ST_LAST_RD : ST_PROBE;
         end
         ST_LAST_RD: begin
            edge_rd_addr = lo_ff[EDGE_IDX_W-1:0];
            if (lo_ff < end_ff) begin
               st_in = ST_LAST;
            end else begin
               rsp_in.status = STAT_NOEDGE;
               rsp_valid_in = 1'b1;
               st_in = ST_IDLE;
            end
         end
         ST_LAST: begin
            rsp_in.word_index_out = word_ff;
            rsp_in.depth_out = depth_ff;
            if (edge_q.pattern == pat_ff) begin
               rsp_in.status = STAT_FOUND;
               rsp_in.child_node = edge_q.child;
            end else begin
               rsp_in.status = STAT_NOEDGE;
               rsp_in.child_node = '0;
            end
            rsp_valid_in = 1'b1;
            st_in = ST_IDLE;
         end
         default: begin
            st_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         st_ff <= st_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      lo_ff <= lo_in;
      len_ff <= len_in;
      end_ff <= end_in;
      pat_ff <= pat_in;
      solv_ff <= solv_in;
      word_ff <= word_in;
      depth_ff <= depth_in;
      rsp_ff <= rsp_in;
   end

   // node store: one write port, two registered read ports (node and its successor)
   always_ff @(posedge clock) begin
      if (node_we) begin
         node_mem[pop_item.node_id] <= '{word_index: pop_item.word_index,
                                         node_depth: pop_item.node_depth,
                                         edge_offset: pop_item.edge_offset};
      end
      node_a_q <= node_mem[node_rd_a];
      node_b_q <= node_mem[node_rd_b];
   end

   // edge store: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (edge_we) begin
         edge_mem[pop_item.edge_index] <= '{pattern: pop_item.pattern,
                                            child: pop_item.child};
      end
      edge_q <= edge_mem[edge_rd_addr];
   end

   property p_busy_output_empty;
      @(posedge clock) disable iff (reset)
         (st_ff != ST_IDLE) |-> !rsp_valid_ff;
   endproperty
   a_busy_output_empty: assert property (p_busy_output_empty)
      else $error("result register full while a lookup is in flight");

   property p_probe_len_nonzero;
      @(posedge clock) disable iff (reset)
         (st_ff == ST_PROBE) |-> (len_ff != '0);
   endproperty
   a_probe_len_nonzero: assert property (p_probe_len_nonzero)
      else $error("probe issued on an empty search window");

   property p_window_in_slice;
      @(posedge clock) disable iff (reset)
         (st_ff == ST_PROBE || st_ff == ST_CMP)
            |-> ((17'(lo_ff) + 17'(len_ff)) <= 17'(end_ff));
   endproperty
   a_window_in_slice: assert property (p_window_in_slice)
      else $error("search window runs past the end of the slice");

   property p_pop_only_idle;
      @(posedge clock) disable iff (reset)
         pop_ready |-> (st_ff == ST_IDLE);
   endproperty
   a_pop_only_idle: assert property (p_pop_only_idle)
      else $error("command taken while the sequencer is busy");

endmodule

/* sv/csr_edge_lookup_core.sv */
// top level of the csr edge lookup block: registers, front, queue and back
// Lookup store for a decision tree in compressed-sparse-row form. A node or edge
// write, a skipped write and an out-of-range lookup are answered straight from the
// idle state; a solved lookup or an empty slice is answered after the node read; a
// search reads the node pair and then runs p binary-search probes, where p is at
// most floor(log2(slice length)) + 1, before a last edge read and compare; each
// probe is one registered read of the single edge store port followed by a compare.
// The back end works on one item at a time while a two-entry queue and the
// result register let the front keep taking items. There is no clearing pass:
// records must be written before a lookup reads them. The node limit and the solved
// pattern are written through the APB-style port at byte addresses 0 and 4
// (paddr[2] selects).
module csr_edge_lookup_core (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  cel_pkg::req_type                    req_item,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output cel_pkg::rsp_type                    rsp_item,
   input  logic                                psel,
   input  logic                                penable,
   input  logic                                pwrite,
   input  logic [cel_pkg::CSR_ADDR_W-1:0]      paddr,
   input  logic [cel_pkg::CSR_DATA_W-1:0]      pwdata,
   output logic [cel_pkg::CSR_DATA_W-1:0]      prdata,
   output logic                                pready
);
   import cel_pkg::*;

   logic [NODE_ID_W-1:0] node_limit_ff, node_limit_in;
   logic [PAT_W-1:0]     solved_ff, solved_in;
   logic                 csr_wr;
   cfg_type              cfg;

   logic    push_valid, push_ready, pop_valid, pop_ready;
   cmd_type push_item, pop_item;

   assign pready = 1'b1;
   assign csr_wr = psel && penable && pwrite && pready;

   always_comb begin
      node_limit_in = node_limit_ff;
      solved_in = solved_ff;
      if (csr_wr) begin
         unique case (paddr[2])
            REG_NODE_LIMIT:     node_limit_in = pwdata[NODE_ID_W-1:0];
            REG_SOLVED_PATTERN: solved_in = pwdata[PAT_W-1:0];
            default:            node_limit_in = node_limit_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         node_limit_ff <= NODE_LIMIT_RESET;
         solved_ff <= SOLVED_PATTERN_RESET;
      end else begin
         node_limit_ff <= node_limit_in;
         solved_ff <= solved_in;
      end
   end

   always_comb begin
      unique case (paddr[2])
         REG_NODE_LIMIT:     prdata = CSR_DATA_W'(node_limit_ff);
         REG_SOLVED_PATTERN: prdata = CSR_DATA_W'(solved_ff);
         default:            prdata = '0;
      endcase
   end

   assign cfg.node_limit = node_limit_ff;
   assign cfg.solved_pattern = solved_ff;

   cel_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_item   (req_item),
      .cfg        (cfg),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_item  (push_item)
   );

   cel_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_item  (push_item),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_item   (pop_item)
   );

   cel_back u_back (
      .clock     (clock),
      .reset     (reset),
      .pop_valid (pop_valid),
      .pop_ready (pop_ready),
      .pop_item  (pop_item),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_item  (rsp_item)
   );

endmodule
